[sv/ndd_pkg.sv]
// ----------------------------------------------------------------------------
// ndd_pkg
// Shared types, constants and fixed-point helpers of the Newton
// divided-difference interpolator.
// ----------------------------------------------------------------------------
package ndd_pkg;

   localparam int MAX_POINTS = 64;
   localparam int IDX_W = $clog2(MAX_POINTS);
   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam int FRAC_W = 16;
   localparam int DVD_W = 32 + FRAC_W;
   localparam int DCNT_W = $clog2(DVD_W + 1);

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_RANGE   = 3'd1;
   localparam logic [2:0] ST_NOTABLE = 3'd2;
   localparam logic [2:0] ST_REPEAT  = 3'd3;
   localparam logic [2:0] ST_FULL    = 3'd4;

   localparam logic [31:0] Q_ONE   = 32'h0001_0000;
   localparam logic [31:0] SAT_MAX = 32'h7fff_ffff;
   localparam logic [31:0] SAT_MIN = 32'h8000_0000;

   typedef struct packed {
      logic               action;
      logic signed [31:0] x_value;
      logic signed [31:0] y_value;
      logic               last_point;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_value;
      logic [2:0]         status;
   } rsp_type;

   typedef enum logic [4:0] {
      S_IDLE, S_L_CHK, S_L_SRD, S_L_SCMP, S_L_MRD, S_L_MWR, S_L_PUT, S_L_END,
      S_B_INIT, S_B_C0, S_B_RD1, S_B_RD2, S_B_GO, S_B_DIV, S_B_WR,
      S_E_CHK, S_E_HI, S_E_RNG, S_E_C0, S_E_RD, S_E_M1, S_E_P, S_E_M2, S_E_ACC,
      S_EMIT
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_CAPTURE, OP_L_CHK, OP_L_SRD, OP_L_SCMP, OP_L_MRD, OP_L_MWR,
      OP_L_PUT, OP_B_INIT, OP_B_C0, OP_B_RD1, OP_B_RD2, OP_B_GO, OP_B_WR,
      OP_E_CHK, OP_E_HI, OP_E_RNG, OP_E_C0, OP_E_RD, OP_E_M1, OP_E_P, OP_E_M2,
      OP_E_ACC, OP_EMIT
   } op_type;

   typedef struct packed {
      op_type op;
      logic   ready;
   } cmd_type;

   typedef struct packed {
      logic req_eval;
      logic full;
      logic scan_end;
      logic scan_lt;
      logic scan_eq;
      logic move_done;
      logic last;
      logic ins_ok;
      logic cnt_zero;
      logic outer_done;
      logic inner_done;
      logic notable;
      logic out_of_range;
      logic eval_done;
      logic div_done;
      logic out_free;
   } stat_type;

   function automatic logic [31:0] sat_diff(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] v;
      v = {a[31], a} - {b[31], b};
      if (v[32] != v[31]) begin
         return v[32] ? SAT_MIN : SAT_MAX;
      end
      return v[31:0];
   endfunction

   function automatic logic [31:0] sat_sum(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] v;
      v = {a[31], a} + {b[31], b};
      if (v[32] != v[31]) begin
         return v[32] ? SAT_MIN : SAT_MAX;
      end
      return v[31:0];
   endfunction

   // Scales a full product back to Q16.16, rounding toward zero.
   function automatic logic [31:0] q_scale(input logic [63:0] p);
      logic [63:0] t;
      logic [63:0] s;
      t = p + (p[63] ? 64'd65535 : 64'd0);
      s = 64'($signed(t) >>> FRAC_W);
      if ((&s[63:31]) || (~|s[63:31])) begin
         return s[31:0];
      end
      return s[63] ? SAT_MIN : SAT_MAX;
   endfunction

endpackage

[sv/ndd_div.sv]
// ----------------------------------------------------------------------------
// ndd_div
// Radix-2 restoring divider for Q16.16 quotients, one bit per cycle,
// truncating toward zero and saturating to 32 bits.
// ----------------------------------------------------------------------------
module ndd_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] num,
   input  logic [31:0] den,
   output logic        done,
   output logic [31:0] quot
);
   import ndd_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic [31:0]       rem_ff, rem_in;
   logic [DVD_W-1:0]  dvd_ff, dvd_in;
   logic [31:0]       dvs_ff, dvs_in;
   logic              neg_ff, neg_in;
   logic              dz_ff, dz_in;
   logic [32:0]       rem_sh;
   logic              ge;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      dz_in   = dz_ff;
      rem_sh  = {rem_ff, dvd_ff[DVD_W-1]};
      ge      = rem_sh >= {1'b0, dvs_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DCNT_W'(DVD_W);
         rem_in  = '0;
         dvd_in  = {(num[31] ? 32'(-num) : num), {FRAC_W{1'b0}}};
         dvs_in  = den[31] ? 32'(-den) : den;
         neg_in  = num[31] ^ den[31];
         dz_in   = den == '0;
      end else if (busy_ff) begin
         rem_in = ge ? 32'(rem_sh - {1'b0, dvs_ff}) : rem_sh[31:0];
         dvd_in = {dvd_ff[DVD_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DCNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_comb begin
      if (dz_ff) begin
         quot = '0;
      end else if (!neg_ff) begin
         quot = (|dvd_ff[DVD_W-1:31]) ? SAT_MAX : dvd_ff[31:0];
      end else if ((|dvd_ff[DVD_W-1:32]) || (dvd_ff[31] && (|dvd_ff[30:0]))) begin
         quot = SAT_MIN;
      end else begin
         quot = 32'(-dvd_ff[31:0]);
      end
   end

   assign done = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
      dz_ff  <= dz_in;
   end

endmodule

[sv/ndd_ctrl.sv]
// ----------------------------------------------------------------------------
// ndd_ctrl
// Sequencer of the interpolator: insertion, table build, evaluation and
// result hand-off.
// ----------------------------------------------------------------------------
module ndd_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  ndd_pkg::stat_type stat,
   output ndd_pkg::cmd_type  cmd
);
   import ndd_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_valid) state_in = stat.req_eval ? S_E_CHK : S_L_CHK;
         S_L_CHK:  state_in = stat.full ? S_L_END : S_L_SRD;
         S_L_SRD:  state_in = stat.scan_end ? S_L_MRD : S_L_SCMP;
         S_L_SCMP: begin
            if (stat.scan_lt) state_in = S_L_SRD;
            else if (stat.scan_eq) state_in = S_L_END;
            else state_in = S_L_MRD;
         end
         S_L_MRD:  state_in = stat.move_done ? S_L_PUT : S_L_MWR;
         S_L_MWR:  state_in = S_L_MRD;
         S_L_PUT:  state_in = S_L_END;
         S_L_END: begin
            if (stat.last) state_in = S_B_INIT;
            else if (stat.ins_ok) state_in = S_IDLE;
            else state_in = S_EMIT;
         end
         S_B_INIT: state_in = stat.cnt_zero ? S_EMIT : S_B_C0;
         S_B_C0:   state_in = S_B_RD1;
         S_B_RD1: begin
            if (stat.outer_done) state_in = S_EMIT;
            else if (!stat.inner_done) state_in = S_B_RD2;
         end
         S_B_RD2:  state_in = S_B_GO;
         S_B_GO:   state_in = S_B_DIV;
         S_B_DIV:  if (stat.div_done) state_in = S_B_WR;
         S_B_WR:   state_in = S_B_RD1;
         S_E_CHK:  state_in = stat.notable ? S_EMIT : S_E_HI;
         S_E_HI:   state_in = S_E_RNG;
         S_E_RNG:  state_in = stat.out_of_range ? S_EMIT : S_E_C0;
         S_E_C0:   state_in = S_E_RD;
         S_E_RD:   state_in = stat.eval_done ? S_EMIT : S_E_M1;
         S_E_M1:   state_in = S_E_P;
         S_E_P:    state_in = S_E_M2;
         S_E_M2:   state_in = S_E_ACC;
         S_E_ACC:  state_in = S_E_RD;
         S_EMIT:   if (stat.out_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd.ready = 1'b0;
      cmd.op    = OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            cmd.ready = 1'b1;
            if (req_valid) cmd.op = OP_CAPTURE;
         end
         S_L_CHK:  cmd.op = OP_L_CHK;
         S_L_SRD:  cmd.op = OP_L_SRD;
         S_L_SCMP: cmd.op = OP_L_SCMP;
         S_L_MRD:  cmd.op = OP_L_MRD;
         S_L_MWR:  cmd.op = OP_L_MWR;
         S_L_PUT:  cmd.op = OP_L_PUT;
         S_L_END:  cmd.op = OP_NONE;
         S_B_INIT: cmd.op = OP_B_INIT;
         S_B_C0:   cmd.op = OP_B_C0;
         S_B_RD1:  cmd.op = OP_B_RD1;
         S_B_RD2:  cmd.op = OP_B_RD2;
         S_B_GO:   cmd.op = OP_B_GO;
         S_B_DIV:  cmd.op = OP_NONE;
         S_B_WR:   cmd.op = OP_B_WR;
         S_E_CHK:  cmd.op = OP_E_CHK;
         S_E_HI:   cmd.op = OP_E_HI;
         S_E_RNG:  cmd.op = OP_E_RNG;
         S_E_C0:   cmd.op = OP_E_C0;
         S_E_RD:   cmd.op = OP_E_RD;
         S_E_M1:   cmd.op = OP_E_M1;
         S_E_P:    cmd.op = OP_E_P;
         S_E_M2:   cmd.op = OP_E_M2;
         S_E_ACC:  cmd.op = OP_E_ACC;
         S_EMIT:   cmd.op = OP_EMIT;
         default:  cmd.op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[sv/ndd_dp.sv]
// ----------------------------------------------------------------------------
// ndd_dp
// Datapath of the interpolator: point, difference and coefficient stores,
// shared multiplier, divider and the result register.
// ----------------------------------------------------------------------------
module ndd_dp (
   input  logic              clock,
   input  logic              reset,
   input  ndd_pkg::cmd_type  cmd,
   input  ndd_pkg::req_type  req_data,
   output ndd_pkg::stat_type stat,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ndd_pkg::rsp_type  rsp_data
);
   import ndd_pkg::*;

   logic [31:0] xmem [MAX_POINTS];
   logic [31:0] dmem [MAX_POINTS];
   logic [31:0] cmem [MAX_POINTS];

   logic [31:0]      xr_ff, dr_ff, cr_ff;
   logic [IDX_W-1:0] xa, da, ca;
   logic             xwe, dwe, cwe;
   logic [IDX_W-1:0] xwa, dwa, cwa;
   logic [31:0]      xwd, dwd, cwd;

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             tready_ff, tready_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic             act_ff, act_in;
   logic             last_ff, last_in;
   logic [31:0]      qx_ff, qx_in;
   logic [31:0]      qy_ff, qy_in;
   logic [2:0]       st_ff, st_in;
   logic [31:0]      acc_ff, acc_in;
   logic [31:0]      prod_ff, prod_in;
   logic [31:0]      cv_ff, cv_in;
   logic [31:0]      lo_ff, lo_in;
   logic [31:0]      hd_ff, hd_in;
   logic [31:0]      hx_ff, hx_in;
   logic [63:0]      mul_ff, mul_in;
   logic             rv_ff, rv_in;
   rsp_type          rsp_ff, rsp_in;

   logic             div_start;
   logic             div_done;
   logic [31:0]      div_quot;
   logic [31:0]      div_num, div_den;
   logic [CNT_W:0]   jk;
   logic [CNT_W-1:0] idx_m1;
   logic [31:0]      qd;

   ndd_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign jk     = {1'b0, idx_ff} + {1'b0, k_ff};
   assign idx_m1 = idx_ff - 1'b1;
   assign div_num = sat_diff(hd_ff, dr_ff);
   assign div_den = sat_diff(hx_ff, xr_ff);
   assign qd      = sat_diff(qx_ff, xr_ff);

   always_comb begin
      stat.req_eval     = req_data.action;
      stat.full         = cnt_ff == CNT_W'(MAX_POINTS);
      stat.scan_end     = idx_ff == cnt_ff;
      stat.scan_lt      = $signed(xr_ff) < $signed(qx_ff);
      stat.scan_eq      = xr_ff == qx_ff;
      stat.move_done    = idx_ff == pos_ff;
      stat.last         = last_ff;
      stat.ins_ok       = st_ff == ST_OK;
      stat.cnt_zero     = cnt_ff == '0;
      stat.outer_done   = k_ff == cnt_ff;
      stat.inner_done   = jk == {1'b0, cnt_ff};
      stat.notable      = !tready_ff || (cnt_ff == '0);
      stat.out_of_range = ($signed(qx_ff) < $signed(lo_ff)) ||
                          ($signed(qx_ff) > $signed(xr_ff));
      stat.eval_done    = idx_ff == cnt_ff;
      stat.div_done     = div_done;
      stat.out_free     = !rv_ff || rsp_ready;
   end

   always_comb begin
      cnt_in    = cnt_ff;
      tready_in = tready_ff;
      idx_in    = idx_ff;
      pos_in    = pos_ff;
      k_in      = k_ff;
      act_in    = act_ff;
      last_in   = last_ff;
      qx_in     = qx_ff;
      qy_in     = qy_ff;
      st_in     = st_ff;
      acc_in    = acc_ff;
      prod_in   = prod_ff;
      cv_in     = cv_ff;
      lo_in     = lo_ff;
      hd_in     = hd_ff;
      hx_in     = hx_ff;
      mul_in    = mul_ff;
      rv_in     = rv_ff;
      rsp_in    = rsp_ff;
      xa  = idx_ff[IDX_W-1:0];
      da  = idx_ff[IDX_W-1:0];
      ca  = idx_ff[IDX_W-1:0];
      xwe = 1'b0;
      dwe = 1'b0;
      cwe = 1'b0;
      xwa = idx_ff[IDX_W-1:0];
      dwa = idx_ff[IDX_W-1:0];
      cwa = k_ff[IDX_W-1:0];
      xwd = xr_ff;
      dwd = dr_ff;
      cwd = div_quot;
      div_start = 1'b0;
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      unique case (cmd.op)
         OP_CAPTURE: begin
            act_in  = req_data.action;
            last_in = req_data.last_point;
            qx_in   = req_data.x_value;
            qy_in   = req_data.y_value;
            st_in   = ST_OK;
            acc_in  = '0;
            if (!req_data.action && tready_ff) begin
               cnt_in    = '0;
               tready_in = 1'b0;
            end
         end
         OP_L_CHK: begin
            if (stat.full) st_in = ST_FULL;
            idx_in = '0;
         end
         OP_L_SRD: begin
            if (stat.scan_end) pos_in = idx_ff;
         end
         OP_L_SCMP: begin
            if (stat.scan_lt) begin
               idx_in = idx_ff + 1'b1;
            end else if (stat.scan_eq) begin
               st_in = ST_REPEAT;
            end else begin
               pos_in = idx_ff;
               idx_in = cnt_ff;
            end
         end
         OP_L_MRD: begin
            xa = idx_m1[IDX_W-1:0];
            da = idx_m1[IDX_W-1:0];
         end
         OP_L_MWR: begin
            xwe    = 1'b1;
            dwe    = 1'b1;
            idx_in = idx_m1;
         end
         OP_L_PUT: begin
            xwe    = 1'b1;
            dwe    = 1'b1;
            xwa    = pos_ff[IDX_W-1:0];
            dwa    = pos_ff[IDX_W-1:0];
            xwd    = qx_ff;
            dwd    = qy_ff;
            cnt_in = cnt_ff + 1'b1;
         end
         OP_B_INIT: begin
            da = '0;
            if (stat.cnt_zero) tready_in = 1'b0;
         end
         OP_B_C0: begin
            cwe    = 1'b1;
            cwa    = '0;
            cwd    = dr_ff;
            k_in   = CNT_W'(1);
            idx_in = '0;
         end
         OP_B_RD1: begin
            da = idx_ff[IDX_W-1:0] + 1'b1;
            xa = jk[IDX_W-1:0];
            if (stat.outer_done) begin
               tready_in = 1'b1;
            end else if (stat.inner_done) begin
               k_in   = k_ff + 1'b1;
               idx_in = '0;
            end
         end
         OP_B_RD2: begin
            hd_in = dr_ff;
            hx_in = xr_ff;
         end
         OP_B_GO: begin
            div_start = 1'b1;
         end
         OP_B_WR: begin
            dwe    = 1'b1;
            dwd    = div_quot;
            cwe    = idx_ff == '0;
            idx_in = idx_ff + 1'b1;
         end
         OP_E_CHK: begin
            xa = '0;
            if (stat.notable) st_in = ST_NOTABLE;
         end
         OP_E_HI: begin
            lo_in = xr_ff;
            xa    = IDX_W'(cnt_ff - 1'b1);
         end
         OP_E_RNG: begin
            ca = '0;
            if (stat.out_of_range) st_in = ST_RANGE;
         end
         OP_E_C0: begin
            acc_in  = cr_ff;
            prod_in = Q_ONE;
            idx_in  = CNT_W'(1);
         end
         OP_E_RD: begin
            xa = idx_m1[IDX_W-1:0];
         end
         OP_E_M1: begin
            cv_in  = cr_ff;
            mul_in = $signed({{32{prod_ff[31]}}, prod_ff}) * $signed({{32{qd[31]}}, qd});
         end
         OP_E_P: begin
            prod_in = q_scale(mul_ff);
         end
         OP_E_M2: begin
            mul_in = $signed({{32{cv_ff[31]}}, cv_ff}) * $signed({{32{prod_ff[31]}}, prod_ff});
         end
         OP_E_ACC: begin
            acc_in = sat_sum(acc_ff, q_scale(mul_ff));
            idx_in = idx_ff + 1'b1;
         end
         OP_EMIT: begin
            if (stat.out_free) begin
               rv_in               = 1'b1;
               rsp_in.status       = st_ff;
               rsp_in.result_value = (act_ff && (st_ff == ST_OK)) ? acc_ff : '0;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid = rv_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (xwe) xmem[xwa] <= xwd;
      if (dwe) dmem[dwa] <= dwd;
      if (cwe) cmem[cwa] <= cwd;
      xr_ff <= xmem[xa];
      dr_ff <= dmem[da];
      cr_ff <= cmem[ca];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         tready_ff <= 1'b0;
         rv_ff     <= 1'b0;
      end else begin
         cnt_ff    <= cnt_in;
         tready_ff <= tready_in;
         rv_ff     <= rv_in;
      end
      idx_ff  <= idx_in;
      pos_ff  <= pos_in;
      k_ff    <= k_in;
      act_ff  <= act_in;
      last_ff <= last_in;
      qx_ff   <= qx_in;
      qy_ff   <= qy_in;
      st_ff   <= st_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      cv_ff   <= cv_in;
      lo_ff   <= lo_in;
      hd_ff   <= hd_in;
      hx_ff   <= hx_in;
      mul_ff  <= mul_in;
      rsp_ff  <= rsp_in;
   end

endmodule

[sv/newton_divided_difference_interp_top.sv]
// A load stores one point in the sorted store; the last point adds the
// table build, n(n-1)/2 divided differences for n stored points, each
// through the one-bit-per-cycle divider. One word is in flight at a time;
// the next is taken once the result is registered, or once a point that is
// not the last is stored. Reset empties the point set; stores need no clearing pass.
// ----------------------------------------------------------------------------
// newton_divided_difference_interp_top
// Newton divided-difference interpolator in signed Q16.16.
// ----------------------------------------------------------------------------
module newton_divided_difference_interp_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ndd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ndd_pkg::rsp_type rsp_data
);
   import ndd_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   ndd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   ndd_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign req_ready = cmd.ready;

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status <= ST_FULL))
      else $error("result status code out of range");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status != ST_OK)) |-> (rsp_data.result_value == '0))
      else $error("error result carries a nonzero value");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second word taken while one is in work");

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// Newton interpolator testbench
// Loads sets of sample points and queries the polynomial through the
// request channel. Every response is checked against a software predictor
// of the point store, the divided-difference table and the evaluation, or
// for pinned words against a fixed response. Directed words come first, then
// random sets with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import ndd_pkg::*;

   localparam int IDLE_LIMIT = 400000;
   localparam int WORD_TARGET = 1350;
   localparam int ONE = 65536;

   typedef struct {
      req_type w;
      bit      pinned;
      rsp_type pinned_rsp;
   } stim_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   stim_type stim[$];
   rsp_type  expected_rsp[$];
   int       accepted_words = 0;
   int       mismatches = 0;
   int       idle_cycles = 0;

   int unsigned sorted_x[MAX_POINTS];
   int          newton_coef[MAX_POINTS];
   int          diff_col[MAX_POINTS];
   int          n_points = 0;
   bit          have_table = 1'b0;

   newton_divided_difference_interp_top DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #10 clock = ~clock;

   function automatic int sat32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return int'(v);
   endfunction

   function automatic int q_mul(int a, int b);
      longint p;
      p = longint'(a) * longint'(b);
      return sat32(p / 65536);
   endfunction

   function automatic int q_div(int num, int den);
      if (den == 0) return 0;
      return sat32((longint'(num) * 65536) / longint'(den));
   endfunction

   function automatic void build_newton_table();
      int num;
      int den;
      if (n_points == 0) begin
         have_table = 1'b0;
         return;
      end
      newton_coef[0] = diff_col[0];
      for (int k = 1; k < n_points; k++) begin
         for (int j = 0; j + k < n_points; j++) begin
            num = sat32(longint'(diff_col[j+1]) - longint'(diff_col[j]));
            den = sat32(longint'(int'(sorted_x[j+k])) - longint'(int'(sorted_x[j])));
            diff_col[j] = q_div(num, den);
         end
         newton_coef[k] = diff_col[0];
      end
      have_table = 1'b1;
   endfunction

   function automatic logic [2:0] insert_sample(int x, int y);
      int pos;
      pos = 0;
      if (n_points >= MAX_POINTS) return ST_FULL;
      while (pos < n_points && int'(sorted_x[pos]) < x) pos++;
      if (pos < n_points && int'(sorted_x[pos]) == x) return ST_REPEAT;
      for (int i = n_points; i > pos; i--) begin
         sorted_x[i] = sorted_x[i-1];
         diff_col[i] = diff_col[i-1];
      end
      sorted_x[pos] = x;
      diff_col[pos] = y;
      n_points++;
      return ST_OK;
   endfunction

   function automatic bit predict_word(req_type w, output rsp_type r);
      int prod;
      int acc;
      int q;
      r = '0;
      q = w.x_value;
      if (w.action == 1'b0) begin
         if (have_table) begin
            n_points = 0;
            have_table = 1'b0;
         end
         r.status = insert_sample(w.x_value, w.y_value);
         if (w.last_point) begin
            build_newton_table();
         end else if (r.status == ST_OK) begin
            return 1'b0;
         end
      end else if (!have_table || n_points == 0) begin
         r.status = ST_NOTABLE;
      end else if (q < int'(sorted_x[0]) || q > int'(sorted_x[n_points-1])) begin
         r.status = ST_RANGE;
      end else begin
         prod = ONE;
         acc = newton_coef[0];
         for (int i = 1; i < n_points; i++) begin
            prod = q_mul(prod, sat32(longint'(q) - longint'(int'(sorted_x[i-1]))));
            acc = sat32(longint'(acc) + longint'(q_mul(newton_coef[i], prod)));
         end
         r.result_value = acc;
         r.status = ST_OK;
      end
      return 1'b1;
   endfunction

   function automatic void add_word(bit act, int x, int y, bit last,
                                    bit pin = 0, logic [2:0] st = ST_OK, int v = 0);
      stim_type s;
      s.w.action = act;
      s.w.x_value = x;
      s.w.y_value = y;
      s.w.last_point = last;
      s.pinned = pin;
      s.pinned_rsp.result_value = v;
      s.pinned_rsp.status = st;
      stim.push_back(s);
   endfunction

   function automatic int rand_coord();
      if ($urandom_range(0, 9) < 7) return int'($urandom_range(0, 32 * ONE)) - 16 * ONE;
      return int'($urandom());
   endfunction

   function automatic void add_random_set(int n, bit to_full);
      int xs[$];
      int lo;
      int hi;
      int x;
      int q;
      for (int i = 0; i < n; i++) begin
         if (xs.size() > 0 && $urandom_range(0, 19) == 0) begin
            x = xs[$urandom_range(0, xs.size() - 1)];
         end else begin
            x = to_full ? i * ONE : rand_coord();
         end
         xs.push_back(x);
         add_word(1'b0, x, rand_coord(), i == n - 1);
         if (!to_full && $urandom_range(0, 29) == 0) add_word(1'b1, rand_coord(), 0, 0);
      end
      lo = xs[0];
      hi = xs[0];
      foreach (xs[i]) begin
         if (xs[i] < lo) lo = xs[i];
         if (xs[i] > hi) hi = xs[i];
      end
      repeat ($urandom_range(1, 6)) begin
         case ($urandom_range(0, 9))
            0: q = int'($urandom());
            1: q = $urandom_range(0, 1) ? lo - 1 : hi + 1;
            2: q = $urandom_range(0, 1) ? lo : hi;
            default: q = lo + int'(longint'($urandom()) % (longint'(hi) - lo + 1));
         endcase
         add_word(1'b1, q, int'($urandom()), $urandom_range(0, 1));
      end
   endfunction

   initial begin
      int burst_left;
      // Directed words: empty store, incomplete load, repeats, range edges,
      // a single point, saturating extremes and a dropped last point.
      add_word(1, 0, 0, 0, 1, ST_NOTABLE);
      add_word(0, 0, 5 * ONE, 0);
      add_word(1, 0, 0, 0, 1, ST_NOTABLE);
      add_word(0, 0, 1, 0, 1, ST_REPEAT);
      add_word(0, ONE, 7 * ONE, 1, 1, ST_OK);
      add_word(1, 0, 0, 0);
      add_word(1, ONE / 2, -1, 1);
      add_word(1, -1, 0, 0, 1, ST_RANGE);
      add_word(1, ONE + 1, 0, 0, 1, ST_RANGE);
      add_word(0, 3 * ONE, 9 * ONE, 1, 1, ST_OK);
      add_word(1, 3 * ONE, 0, 0, 1, ST_OK, 9 * ONE);
      add_word(0, 32'sh80000000, 32'sh80000000, 0);
      add_word(0, 32'sh7fffffff, 32'sh7fffffff, 0);
      add_word(0, 0, 32'sh7fffffff, 1, 1, ST_OK);
      add_word(1, 32'sh80000000, 0, 0);
      add_word(1, 32'sh7fffffff, 0, 0);
      add_word(1, 0, 0, 0);
      add_word(1, -ONE, 0, 0);
      add_word(0, 5 * ONE, -2 * ONE, 0);
      add_word(0, 5 * ONE, 4 * ONE, 1, 1, ST_REPEAT);
      add_word(1, 5 * ONE, 0, 0, 1, ST_OK, -2 * ONE);
      while (stim.size() < WORD_TARGET) begin
         if (stim.size() > 200 && stim.size() < 280) begin
            add_random_set(MAX_POINTS + 2, 1);
         end else begin
            add_random_set($urandom_range(0, 6) == 0 ? $urandom_range(9, 16)
                                                     : $urandom_range(2, 8), 0);
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      burst_left = 0;
      foreach (stim[k]) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 2) != 0) begin
               req_valid <= 1'b0;
               repeat ($urandom_range(1, 6)) @(posedge clock);
            end
         end
         burst_left--;
         req_data <= stim[k].w;
         req_valid <= 1'b1;
         do @(posedge clock); while (!req_ready);
      end
      req_valid <= 1'b0;
      wait (accepted_words == stim.size() && expected_rsp.size() == 0);
      repeat (300) @(posedge clock);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   always @(posedge clock) begin
      int phase;
      phase = (accepted_words / 40) % 4;
      case (phase)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= $urandom_range(0, 1);
         2: rsp_ready <= ($urandom_range(0, 3) != 0);
         default: rsp_ready <= ($urandom_range(0, 4) == 0);
      endcase
   end

   always @(posedge clock) begin
      rsp_type r;
      rsp_type e;
      bit      progress;
      if (!reset) begin
         progress = 1'b0;
         if (req_valid && req_ready) begin
            progress = 1'b1;
            if (predict_word(req_data, r)) begin
               if (stim[accepted_words].pinned) r = stim[accepted_words].pinned_rsp;
               expected_rsp.push_back(r);
            end
            accepted_words++;
         end
         if (rsp_valid && rsp_ready) begin
            progress = 1'b1;
            if (expected_rsp.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response %p", rsp_data);
            end else begin
               e = expected_rsp.pop_front();
               if (rsp_data.result_value !== e.result_value || rsp_data.status !== e.status) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected value %0d status %0d, got value %0d status %0d",
                              e.result_value, e.status, rsp_data.result_value, rsp_data.status);
               end
            end
         end
         idle_cycles = progress ? 0 : idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

endmodule

[sim.f]
sv/ndd_pkg.sv
sv/ndd_div.sv
sv/ndd_ctrl.sv
sv/ndd_dp.sv
sv/newton_divided_difference_interp_top.sv
tb/sv/testbench.sv
